>>> rtl/core/segint_pkg.sv
// segint_pkg: shared constants and types of the segment intersection core
// no dependencies; used by the core, the divider lane and the port checker

package segint_pkg;

    // default coordinate width, signed Q16.16 at 32 bits
    localparam int COORD_WIDTH = 32;

    // how the two segments are oriented
    typedef enum logic [1:0] {
        SEG_GENERAL   = 2'd0,
        SEG_ONE_VERT  = 2'd1,
        SEG_BOTH_VERT = 2'd2
    } seg_case_t;

endpackage

>>> rtl/core/segment_intersection_core.sv
// segment_intersection_core: streaming 2d segment intersection, fixed point
// depends on segint_pkg and segint_div_lane
//
// usage
//   s_ channel carries one segment pair per transfer; m_ channel carries
//   the hit flag and the intersection point (zero on a miss)
//   one transfer accepted per cycle while the output is not stalled, with no gaps between items
//   the pipeline depth comes from the front end (products, cross terms) and from
//   the divider lanes, which resolve one quotient bit per stage over W+1
//   stages plus four stages of sign and range handling
//   reset clears all valid bits; payload registers keep stale data
//   when the receiver stalls, the whole pipe holds and s_tready drops in
//   the same cycle; nothing is lost or repeated
//   s_tready is high whenever the output register is empty or being read

module segment_intersection_core #(
    parameter int W = segint_pkg::COORD_WIDTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [((8*W+7)/8)*8-1:0]              s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // hit, point_x, point_y, zero fill
    output logic [((2*W+1+7)/8)*8-1:0]            m_tdata
);

    localparam int OUT_W = ((2*W+1+7)/8)*8;
    localparam int EW    = W + 1;
    localparam int PW    = 2*W + 2;
    localparam int DW    = 2*W + 3;
    localparam int NW    = 2*W + 3;
    localparam int TW    = 3*W + 4;
    localparam int H     = NW / 2;
    localparam int LOW_W = EW + H + 1;
    localparam int HIW_W = EW + NW - H;
    localparam int FRONT = 6;
    localparam int LANE  = W + 5;
    localparam int DEPTH = FRONT + LANE;

    typedef struct packed {
        logic signed [W-1:0] xlo;
        logic signed [W-1:0] xhi;
        logic signed [W-1:0] ylo;
        logic signed [W-1:0] yhi;
    } box_t;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // valid bits travel alongside the data
    logic [DEPTH-1:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // stage 0: input capture
    logic signed [W-1:0] c_reg [8];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 8; i++) begin
                c_reg[i] <= $signed(s_tdata[i*W +: W]);
            end
        end
    end

    // stage 1: orientation, edge vectors, coordinate ranges
    logic                 t1_v1_reg, t1_v2_reg, t1_samex_reg;
    logic signed [EW-1:0] t1_ax_reg, t1_ay_reg, t1_bx_reg, t1_by_reg;
    logic signed [EW-1:0] t1_ex_reg, t1_ey_reg, t1_dx_reg, t1_dy_reg, t1_xm_reg;
    logic signed [W-1:0]  t1_xv_reg, t1_ys_reg, t1_fsx_reg, t1_fsy_reg;
    box_t                 t1_fbox_reg, t1_sbox_reg;
    logic                 t1_v1_next;
    logic signed [EW-1:0] t1_ax_next, t1_ay_next, t1_bx_next, t1_by_next;
    logic signed [W-1:0]  t1_xv_next, t1_xs_next;

    assign t1_v1_next = c_reg[0] == c_reg[2];
    assign t1_ax_next = EW'(c_reg[2]) - EW'(c_reg[0]);
    assign t1_ay_next = EW'(c_reg[3]) - EW'(c_reg[1]);
    assign t1_bx_next = EW'(c_reg[6]) - EW'(c_reg[4]);
    assign t1_by_next = EW'(c_reg[7]) - EW'(c_reg[5]);
    assign t1_xv_next = t1_v1_next ? c_reg[0] : c_reg[4];
    assign t1_xs_next = t1_v1_next ? c_reg[4] : c_reg[0];

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_v1_reg    <= t1_v1_next;
            t1_v2_reg    <= c_reg[4] == c_reg[6];
            t1_samex_reg <= c_reg[0] == c_reg[4];
            t1_ax_reg    <= t1_ax_next;
            t1_ay_reg    <= t1_ay_next;
            t1_bx_reg    <= t1_bx_next;
            t1_by_reg    <= t1_by_next;
            t1_ex_reg    <= EW'(c_reg[4]) - EW'(c_reg[0]);
            t1_ey_reg    <= EW'(c_reg[5]) - EW'(c_reg[1]);
            t1_dx_reg    <= t1_v1_next ? t1_bx_next : t1_ax_next;
            t1_dy_reg    <= t1_v1_next ? t1_by_next : t1_ay_next;
            t1_xm_reg    <= EW'(t1_xv_next) - EW'(t1_xs_next);
            t1_xv_reg    <= t1_xv_next;
            t1_ys_reg    <= t1_v1_next ? c_reg[5] : c_reg[1];
            t1_fsx_reg   <= c_reg[0];
            t1_fsy_reg   <= c_reg[1];
            t1_fbox_reg.xlo <= (c_reg[0] <= c_reg[2]) ? c_reg[0] : c_reg[2];
            t1_fbox_reg.xhi <= (c_reg[0] >= c_reg[2]) ? c_reg[0] : c_reg[2];
            t1_fbox_reg.ylo <= (c_reg[1] <= c_reg[3]) ? c_reg[1] : c_reg[3];
            t1_fbox_reg.yhi <= (c_reg[1] >= c_reg[3]) ? c_reg[1] : c_reg[3];
            t1_sbox_reg.xlo <= (c_reg[4] <= c_reg[6]) ? c_reg[4] : c_reg[6];
            t1_sbox_reg.xhi <= (c_reg[4] >= c_reg[6]) ? c_reg[4] : c_reg[6];
            t1_sbox_reg.ylo <= (c_reg[5] <= c_reg[7]) ? c_reg[5] : c_reg[7];
            t1_sbox_reg.yhi <= (c_reg[5] >= c_reg[7]) ? c_reg[5] : c_reg[7];
        end
    end

    // stage 2: cross products, case decode, acceptance boxes
    logic signed [PW-1:0] t2_pab_reg, t2_pba_reg, t2_peb_reg, t2_pfa_reg, t2_pv_reg;
    segint_pkg::seg_case_t t2_case_reg, t2_case_next;
    box_t                 t2_box_reg, t2_box_next;
    logic                 t2_vok_reg, t2_vok_next;
    logic signed [EW-1:0] t2_mid_reg, t2_dx_reg, t2_ax_reg, t2_ay_reg;
    logic signed [W-1:0]  t2_xv_reg, t2_ys_reg, t2_fsx_reg, t2_fsy_reg;
    logic                 swap;
    logic signed [W-1:0]  lo_a, hi_a, lo_b, hi_b;
    box_t                 ss_box, vs_box;

    assign swap = $signed(t1_fbox_reg.ylo) > $signed(t1_sbox_reg.ylo);
    assign lo_a = swap ? t1_sbox_reg.ylo : t1_fbox_reg.ylo;
    assign hi_a = swap ? t1_sbox_reg.yhi : t1_fbox_reg.yhi;
    assign lo_b = swap ? t1_fbox_reg.ylo : t1_sbox_reg.ylo;
    assign hi_b = swap ? t1_fbox_reg.yhi : t1_sbox_reg.yhi;
    assign ss_box = t1_v1_reg ? t1_sbox_reg : t1_fbox_reg;
    assign vs_box = t1_v1_reg ? t1_fbox_reg : t1_sbox_reg;

    always_comb begin
        priority if (t1_v1_reg && t1_v2_reg) begin
            t2_case_next = segint_pkg::SEG_BOTH_VERT;
        end else if (t1_v1_reg || t1_v2_reg) begin
            t2_case_next = segint_pkg::SEG_ONE_VERT;
        end else begin
            t2_case_next = segint_pkg::SEG_GENERAL;
        end
    end

    always_comb begin
        unique case (t2_case_next)
            segint_pkg::SEG_BOTH_VERT: begin
                t2_box_next.xlo = t1_fsx_reg;
                t2_box_next.xhi = t1_fsx_reg;
                t2_box_next.ylo = lo_b;
                t2_box_next.yhi = hi_a;
                t2_vok_next     = t1_samex_reg && (hi_a >= lo_b) && (lo_a <= hi_b);
            end
            segint_pkg::SEG_ONE_VERT: begin
                t2_box_next.xlo = ss_box.xlo;
                t2_box_next.xhi = ss_box.xhi;
                t2_box_next.ylo = vs_box.ylo;
                t2_box_next.yhi = vs_box.yhi;
                t2_vok_next     = (t1_xv_reg >= $signed(ss_box.xlo)) &&
                                  (t1_xv_reg <= $signed(ss_box.xhi));
            end
            default: begin
                t2_box_next.xlo = ($signed(t1_fbox_reg.xlo) >= $signed(t1_sbox_reg.xlo)) ?
                                  t1_fbox_reg.xlo : t1_sbox_reg.xlo;
                t2_box_next.xhi = ($signed(t1_fbox_reg.xhi) <= $signed(t1_sbox_reg.xhi)) ?
                                  t1_fbox_reg.xhi : t1_sbox_reg.xhi;
                t2_box_next.ylo = ($signed(t1_fbox_reg.ylo) >= $signed(t1_sbox_reg.ylo)) ?
                                  t1_fbox_reg.ylo : t1_sbox_reg.ylo;
                t2_box_next.yhi = ($signed(t1_fbox_reg.yhi) <= $signed(t1_sbox_reg.yhi)) ?
                                  t1_fbox_reg.yhi : t1_sbox_reg.yhi;
                t2_vok_next     = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t2_pab_reg  <= t1_ax_reg * t1_by_reg;
            t2_pba_reg  <= t1_ay_reg * t1_bx_reg;
            t2_peb_reg  <= t1_ex_reg * t1_by_reg;
            t2_pfa_reg  <= t1_ey_reg * t1_bx_reg;
            t2_pv_reg   <= t1_dy_reg * t1_xm_reg;
            t2_case_reg <= t2_case_next;
            t2_box_reg  <= t2_box_next;
            t2_vok_reg  <= t2_vok_next;
            t2_mid_reg  <= EW'(hi_a) + EW'(lo_b);
            t2_dx_reg   <= t1_dx_reg;
            t2_ax_reg   <= t1_ax_reg;
            t2_ay_reg   <= t1_ay_reg;
            t2_xv_reg   <= t1_xv_reg;
            t2_ys_reg   <= t1_ys_reg;
            t2_fsx_reg  <= t1_fsx_reg;
            t2_fsy_reg  <= t1_fsy_reg;
        end
    end

    // stage 3: denominator and parameter numerator
    logic signed [DW-1:0] t3_den_reg;
    logic signed [NW-1:0] t3_num_reg;
    logic signed [PW-1:0] t3_pv_reg;
    segint_pkg::seg_case_t t3_case_reg;
    box_t                 t3_box_reg;
    logic                 t3_vok_reg;
    logic signed [EW-1:0] t3_mid_reg, t3_dx_reg, t3_ax_reg, t3_ay_reg;
    logic signed [W-1:0]  t3_xv_reg, t3_ys_reg, t3_fsx_reg, t3_fsy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t3_den_reg  <= DW'(t2_pab_reg) - DW'(t2_pba_reg);
            t3_num_reg  <= NW'(t2_peb_reg) - NW'(t2_pfa_reg);
            t3_pv_reg   <= t2_pv_reg;
            t3_case_reg <= t2_case_reg;
            t3_box_reg  <= t2_box_reg;
            t3_vok_reg  <= t2_vok_reg;
            t3_mid_reg  <= t2_mid_reg;
            t3_dx_reg   <= t2_dx_reg;
            t3_ax_reg   <= t2_ax_reg;
            t3_ay_reg   <= t2_ay_reg;
            t3_xv_reg   <= t2_xv_reg;
            t3_ys_reg   <= t2_ys_reg;
            t3_fsx_reg  <= t2_fsx_reg;
            t3_fsy_reg  <= t2_fsy_reg;
        end
    end

    // stage 4: edge vector times numerator, split into two partial products
    logic signed [LOW_W-1:0] t4_axl_reg, t4_ayl_reg;
    logic signed [HIW_W-1:0] t4_axh_reg, t4_ayh_reg;
    logic signed [DW-1:0]    t4_den_reg;
    logic                    t4_dnz_reg;
    logic signed [PW-1:0]    t4_pv_reg;
    segint_pkg::seg_case_t   t4_case_reg;
    box_t                    t4_box_reg;
    logic                    t4_vok_reg;
    logic signed [EW-1:0]    t4_mid_reg, t4_dx_reg;
    logic signed [W-1:0]     t4_xv_reg, t4_ys_reg, t4_fsx_reg, t4_fsy_reg;
    logic signed [H:0]       num_lo;
    logic signed [NW-H-1:0]  num_hi;

    assign num_lo = $signed({1'b0, t3_num_reg[H-1:0]});
    assign num_hi = t3_num_reg[NW-1:H];

    always_ff @(posedge aclk) begin
        if (en) begin
            t4_axl_reg  <= t3_ax_reg * num_lo;
            t4_axh_reg  <= t3_ax_reg * num_hi;
            t4_ayl_reg  <= t3_ay_reg * num_lo;
            t4_ayh_reg  <= t3_ay_reg * num_hi;
            t4_den_reg  <= t3_den_reg;
            t4_dnz_reg  <= t3_den_reg != '0;
            t4_pv_reg   <= t3_pv_reg;
            t4_case_reg <= t3_case_reg;
            t4_box_reg  <= t3_box_reg;
            t4_vok_reg  <= t3_vok_reg;
            t4_mid_reg  <= t3_mid_reg;
            t4_dx_reg   <= t3_dx_reg;
            t4_xv_reg   <= t3_xv_reg;
            t4_ys_reg   <= t3_ys_reg;
            t4_fsx_reg  <= t3_fsx_reg;
            t4_fsy_reg  <= t3_fsy_reg;
        end
    end

    // stage 5: combine partial products and load the divider lanes
    localparam logic signed [DW-1:0] DEN_ONE = DW'(1);
    localparam logic signed [DW-1:0] DEN_TWO = DW'(2);

    logic signed [TW-1:0] tx, ty;
    logic signed [DW-1:0] lx_den_reg, ly_den_reg, lx_den_next, ly_den_next;
    logic signed [TW-1:0] lx_t_reg, ly_t_reg, lx_t_next, ly_t_next;
    logic signed [W-1:0]  lx_c_reg, ly_c_reg, lx_c_next, ly_c_next;
    box_t                 l_box_reg;
    logic                 l_ok_reg, l_ok_next;

    assign tx = (TW'(t4_axh_reg) <<< H) + TW'(t4_axl_reg);
    assign ty = (TW'(t4_ayh_reg) <<< H) + TW'(t4_ayl_reg);

    always_comb begin
        unique case (t4_case_reg)
            segint_pkg::SEG_BOTH_VERT: begin
                lx_den_next = DEN_ONE;
                lx_t_next   = '0;
                lx_c_next   = t4_fsx_reg;
                ly_den_next = DEN_TWO;
                ly_t_next   = TW'(t4_mid_reg);
                ly_c_next   = '0;
                l_ok_next   = t4_vok_reg;
            end
            segint_pkg::SEG_ONE_VERT: begin
                lx_den_next = DEN_ONE;
                lx_t_next   = '0;
                lx_c_next   = t4_xv_reg;
                ly_den_next = DW'(t4_dx_reg);
                ly_t_next   = TW'(t4_pv_reg);
                ly_c_next   = t4_ys_reg;
                l_ok_next   = t4_vok_reg;
            end
            default: begin
                lx_den_next = t4_den_reg;
                lx_t_next   = tx;
                lx_c_next   = t4_fsx_reg;
                ly_den_next = t4_den_reg;
                ly_t_next   = ty;
                ly_c_next   = t4_fsy_reg;
                l_ok_next   = t4_dnz_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lx_den_reg <= lx_den_next;
            lx_t_reg   <= lx_t_next;
            lx_c_reg   <= lx_c_next;
            ly_den_reg <= ly_den_next;
            ly_t_reg   <= ly_t_next;
            ly_c_reg   <= ly_c_next;
            l_box_reg  <= t4_box_reg;
            l_ok_reg   <= l_ok_next;
        end
    end

    // divider lanes for x and y
    logic signed [W-1:0] px, py;
    logic                px_in, py_in;

    segint_div_lane #(.W(W)) u_lane_x (
        .aclk       (aclk),
        .en         (en),
        .den_i      (lx_den_reg),
        .t_i        (lx_t_reg),
        .c_i        (lx_c_reg),
        .lo_i       (l_box_reg.xlo),
        .hi_i       (l_box_reg.xhi),
        .value_o    (px),
        .in_range_o (px_in)
    );

    segint_div_lane #(.W(W)) u_lane_y (
        .aclk       (aclk),
        .en         (en),
        .den_i      (ly_den_reg),
        .t_i        (ly_t_reg),
        .c_i        (ly_c_reg),
        .lo_i       (l_box_reg.ylo),
        .hi_i       (l_box_reg.yhi),
        .value_o    (py),
        .in_range_o (py_in)
    );

    // case acceptance delayed to match the lanes
    logic [LANE-1:0] ok_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            ok_reg <= {ok_reg[LANE-2:0], l_ok_reg};
        end
    end

    // result assembly
    logic hit;
    assign hit      = ok_reg[LANE-1] && px_in && py_in;
    assign m_tvalid = vld_reg[DEPTH-1];
    assign m_tdata  = {{(OUT_W-2*W-1){1'b0}},
                       hit ? py : {W{1'b0}},
                       hit ? px : {W{1'b0}},
                       hit};

endmodule

>>> rtl/core/segint_div_lane.sv
// segint_div_lane: pipelined value = c + t / den with truncation toward zero,
// plus a range check of the result; one restoring quotient bit per stage
// depends on segint_pkg for the default coordinate width

module segint_div_lane #(
    parameter int W = segint_pkg::COORD_WIDTH
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [2*W+2:0]     den_i,
    input  logic signed [3*W+3:0]     t_i,
    input  logic signed [W-1:0]       c_i,
    input  logic signed [W-1:0]       lo_i,
    input  logic signed [W-1:0]       hi_i,
    output logic signed [W-1:0]       value_o,
    output logic                      in_range_o
);

    localparam int DW = 2*W + 3;
    localparam int TW = 3*W + 4;
    localparam int QW = W + 1;
    localparam int FW = QW + 3;

    typedef struct packed {
        logic [TW-1:0]        r;
        logic [DW-1:0]        d;
        logic [QW-1:0]        q;
        logic                 neg;
        logic                 ovf;
        logic signed [W-1:0]  c;
        logic signed [W-1:0]  lo;
        logic signed [W-1:0]  hi;
    } div_stage_t;

    // sign normalization: divisor made positive
    logic [DW-1:0]        n_d_reg;
    logic signed [TW-1:0] n_t_reg;
    logic signed [W-1:0]  n_c_reg;
    logic signed [W-1:0]  n_lo_reg;
    logic signed [W-1:0]  n_hi_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            n_d_reg  <= den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
            n_t_reg  <= den_i[DW-1] ? -t_i : t_i;
            n_c_reg  <= c_i;
            n_lo_reg <= lo_i;
            n_hi_reg <= hi_i;
        end
    end

    // magnitude and quotient overflow check
    div_stage_t    st_reg [QW+1];
    logic          m_neg;
    logic [TW-1:0] m_mag;
    logic [TW:0]   m_lim;

    assign m_neg = n_t_reg < 0;
    assign m_mag = m_neg ? TW'(-n_t_reg) : TW'(n_t_reg);
    assign m_lim = (TW+1)'(n_d_reg) << QW;

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0].r   <= m_mag;
            st_reg[0].d   <= n_d_reg;
            st_reg[0].q   <= '0;
            st_reg[0].neg <= m_neg;
            st_reg[0].ovf <= {1'b0, m_mag} >= m_lim;
            st_reg[0].c   <= n_c_reg;
            st_reg[0].lo  <= n_lo_reg;
            st_reg[0].hi  <= n_hi_reg;
        end
    end

    // restoring divide, most significant quotient bit first
    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int B = QW - 1 - k;
        logic [TW:0]  trial;
        logic         take;
        div_stage_t   st_next;

        assign trial = (TW+1)'(st_reg[k].d) << B;
        assign take  = {1'b0, st_reg[k].r} >= trial;

        always_comb begin
            st_next = st_reg[k];
            if (take) begin
                st_next.r    = st_reg[k].r - trial[TW-1:0];
                st_next.q[B] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k+1] <= st_next;
            end
        end
    end

    // floor quotient from the magnitude result, then add the offset
    logic signed [QW+1:0] f_qpos;
    logic signed [QW+1:0] f_qf;
    logic                 f_rnz;
    logic signed [FW-1:0] f_sum_reg;
    logic                 f_rnz_reg;
    logic                 f_ovf_reg;
    logic signed [W-1:0]  f_lo_reg;
    logic signed [W-1:0]  f_hi_reg;

    assign f_rnz  = st_reg[QW].r != '0;
    assign f_qpos = $signed({2'b00, st_reg[QW].q});
    assign f_qf   = !st_reg[QW].neg ? f_qpos : (f_rnz ? ~f_qpos : -f_qpos);

    always_ff @(posedge aclk) begin
        if (en) begin
            f_sum_reg <= FW'(st_reg[QW].c) + FW'(f_qf);
            f_rnz_reg <= f_rnz;
            f_ovf_reg <= st_reg[QW].ovf;
            f_lo_reg  <= st_reg[QW].lo;
            f_hi_reg  <= st_reg[QW].hi;
        end
    end

    // truncation fix for negative results with a remainder, then range check
    logic                 adj;
    logic signed [FW-1:0] tr;
    logic signed [W-1:0]  value_reg;
    logic                 in_range_reg;

    assign adj = (f_sum_reg < 0) && f_rnz_reg;
    assign tr  = f_sum_reg + $signed({{(FW-1){1'b0}}, adj});

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg    <= tr[W-1:0];
            in_range_reg <= !f_ovf_reg && (tr >= FW'(f_lo_reg)) && (tr <= FW'(f_hi_reg));
        end
    end

    assign value_o    = value_reg;
    assign in_range_o = in_range_reg;

endmodule

>>> rtl/core/segint_checker.sv
// segint_checker: port-level assertions for segment_intersection_core
// depends on segint_pkg; attached to the core by the bind below

module segint_checker #(
    parameter int W = segint_pkg::COORD_WIDTH
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [((2*W+1+7)/8)*8-1:0]      m_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a miss carries a zero point
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[2*W:1] == '0)
        else $error("miss with nonzero point");

    // input side is ready exactly when the output is free to move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // reset empties the pipe
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a result never becomes valid straight out of reset
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(aresetn))
        else $error("result appeared out of reset");

endmodule

bind segment_intersection_core segint_checker #(.W(W)) u_segint_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sv/testbench.sv
// testbench: self-checking stream test of segment_intersection_core
// depends on segint_pkg and the core; predicts each result and compares fields

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = segint_pkg::COORD_WIDTH;
    localparam int IN_BITS = ((8*CW+7)/8)*8;
    localparam int OUT_BITS = ((2*CW+1+7)/8)*8;
    localparam int LATENCY = CW + 10;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [4*CW+7:0] wide_t;

    typedef struct packed {
        logic   hit;
        coord_t px;
        coord_t py;
    } crossing_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_BITS-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;

    crossing_t expected_crossings[$];
    int mismatch_count = 0;
    int result_count = 0;
    int hit_count = 0;
    int sent_count = 0;
    longint cycle_count = 0;
    int case_count[3] = '{0, 0, 0};

    segment_intersection_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // truncating signed division, zero divisor gives zero
    function automatic wide_t div_trunc(wide_t n, wide_t d);
        wide_t an, ad, q;
        if (d == 0) return 0;
        an = n < 0 ? -n : n;
        ad = d < 0 ? -d : d;
        q = an / ad;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic logic in_range(wide_t v, wide_t e0, wide_t e1);
        wide_t lo, hi;
        lo = e0 < e1 ? e0 : e1;
        hi = e0 < e1 ? e1 : e0;
        return v >= lo && v <= hi;
    endfunction

    // exact intersection of two segments
    function automatic crossing_t intersect_segments(logic [8*CW-1:0] d);
        wide_t c[8];
        wide_t px, py, lo1, hi1, lo2, hi2, t, x, y, dx, dy;
        wide_t ax, ay, bx, by, den, num;
        logic hit, v1, v2;
        int vi, si;
        crossing_t r;
        for (int i = 0; i < 8; i++) c[i] = coord_t'(d[i*CW +: CW]);
        v1 = c[0] == c[2];
        v2 = c[4] == c[6];
        hit = 0; px = 0; py = 0;
        if (v1 && v2) begin
            case_count[segint_pkg::SEG_BOTH_VERT]++;
            if (c[0] == c[4]) begin
                lo1 = c[1] < c[3] ? c[1] : c[3]; hi1 = c[1] < c[3] ? c[3] : c[1];
                lo2 = c[5] < c[7] ? c[5] : c[7]; hi2 = c[5] < c[7] ? c[7] : c[5];
                if (lo1 > lo2) begin
                    t = lo1; lo1 = lo2; lo2 = t;
                    t = hi1; hi1 = hi2; hi2 = t;
                end
                if (hi1 >= lo2 && lo1 <= hi2) begin
                    hit = 1; px = c[0]; py = div_trunc(hi1 + lo2, 2);
                end
            end
        end else if (v1 || v2) begin
            case_count[segint_pkg::SEG_ONE_VERT]++;
            vi = v1 ? 0 : 4;
            si = v1 ? 4 : 0;
            x = c[vi];
            if (in_range(x, c[si], c[si+2])) begin
                dx = c[si+2] - c[si];
                dy = c[si+3] - c[si+1];
                y = div_trunc(c[si+1] * dx + dy * (x - c[si]), dx);
                if (in_range(y, c[vi+1], c[vi+3])) begin
                    hit = 1; px = x; py = y;
                end
            end
        end else begin
            case_count[segint_pkg::SEG_GENERAL]++;
            ax = c[2] - c[0]; ay = c[3] - c[1];
            bx = c[6] - c[4]; by = c[7] - c[5];
            den = ax * by - ay * bx;
            if (den != 0) begin
                num = (c[4] - c[0]) * by - (c[5] - c[1]) * bx;
                x = div_trunc(c[0] * den + ax * num, den);
                y = div_trunc(c[1] * den + ay * num, den);
                if (in_range(x, c[0], c[2]) && in_range(y, c[1], c[3]) &&
                    in_range(x, c[4], c[6]) && in_range(y, c[5], c[7])) begin
                    hit = 1; px = x; py = y;
                end
            end
        end
        r.hit = hit;
        r.px = hit ? coord_t'(px) : '0;
        r.py = hit ? coord_t'(py) : '0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
        mismatch_count++;
        $display("mismatch at result %0d: %s got %h expected %h", result_count, what, got, want);
    endtask

    // receiver stall pattern: runs of ready and stall, with stall-free stretches
    initial begin
        int run;
        forever begin
            run = $urandom_range(1, 40);
            repeat (run) @(posedge aclk) m_tready <= 1'b1;
            if ($urandom_range(0, 3) != 0) begin
                run = $urandom_range(1, 8);
                repeat (run) @(posedge aclk) m_tready <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        crossing_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit = m_tdata[0];
            got.px = m_tdata[1 +: CW];
            got.py = m_tdata[1+CW +: CW];
            if (expected_crossings.size() == 0) begin
                report_mismatch("unexpected result", CW'(m_tdata), '0);
            end else begin
                want = expected_crossings.pop_front();
                if (got.hit !== want.hit) begin
                    report_mismatch("hit", CW'(got.hit), CW'(want.hit));
                end
                if (got.px !== want.px) report_mismatch("point_x", got.px, want.px);
                if (got.py !== want.py) report_mismatch("point_y", got.py, want.py);
                if (want.hit) hit_count++;
            end
            result_count++;
        end
    end

    // one segment pair transfer, held until accepted
    int burst_left = 0;
    task automatic send_pair(coord_t fsx, coord_t fsy, coord_t fex, coord_t fey,
                             coord_t ssx, coord_t ssy, coord_t sex, coord_t sey);
        logic [8*CW-1:0] d;
        d = {sey, sex, ssy, ssx, fey, fex, fsy, fsx};
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= IN_BITS'(d);
        do @(posedge aclk); while (!s_tready);
        expected_crossings.push_back(intersect_segments(d));
        sent_count++;
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
    endtask

    function automatic coord_t any_coord();
        return coord_t'($urandom());
    endfunction

    // small coordinate around a center, keeps crossings likely
    function automatic coord_t near(coord_t ctr, int span);
        return ctr + coord_t'($urandom_range(0, 2*span)) - coord_t'(span);
    endfunction

    task automatic test_extremes();
        coord_t mx, mn;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        send_pair(mn, mn, mx, mx, mn, mx, mx, mn);
        send_pair(mx, mx, mn, mn, mx, mn, mn, mx);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(mn, mn, mn, mx, mn, mx, mn, mn);
        send_pair(mx, mn, mx, mx, mn, 0, mx, 0);
        send_pair(-1, -1, -1, -1, -1, -1, -1, -1);
        send_pair(mx, mx, mx, mx, mx, mx, mx, mx);
    endtask

    task automatic test_both_vertical();
        send_pair(5, 0, 5, 10, 5, 10, 5, 20);
        send_pair(5, 20, 5, 10, 5, 0, 5, 10);
        send_pair(5, 0, 5, 10, 5, 11, 5, 20);
        send_pair(5, 0, 5, 10, 6, 0, 6, 10);
        send_pair(-3, -9, -3, 2, -3, -7, -3, -4);
        send_pair(7, 4, 7, 4, 7, 0, 7, 9);
        send_pair(1, -5, 1, -2, 1, -2, 1, 3);
    endtask

    task automatic test_one_vertical();
        send_pair(4, -10, 4, 10, 0, 0, 10, 3);
        send_pair(0, 0, 10, 3, 4, -10, 4, 10);
        send_pair(4, -10, 4, 1, 0, 0, 10, 30);
        send_pair(11, -10, 11, 10, 0, 0, 10, 3);
        send_pair(10, 0, 10, 3, 0, 0, 10, 3);
        send_pair(-4, 10, -4, -10, 0, 0, -7, 5);
    endtask

    task automatic test_general();
        send_pair(0, 0, 10, 10, 0, 10, 10, 0);
        send_pair(0, 0, 10, 10, 1, 0, 11, 10);
        send_pair(0, 0, 10, 10, 2, 2, 20, 20);
        send_pair(0, 0, 3, 7, 0, 5, 7, 0);
        send_pair(0, 0, 1, 1, 5, 0, 6, -1);
    endtask

    task automatic test_random_pairs(int count);
        coord_t c[8], ctr, vx;
        int span, kind;
        repeat (count) begin
            kind = $urandom_range(0, 9);
            span = ($urandom_range(0, 7) == 0) ? 32'h3fff_ffff : $urandom_range(1, 4000);
            ctr = ($urandom_range(0, 3) == 0) ? any_coord() : near(0, 1 << 20);
            for (int i = 0; i < 8; i++) c[i] = near(ctr, span);
            if (kind == 0) begin
                for (int i = 0; i < 8; i++) c[i] = any_coord();
            end else if (kind <= 2) begin
                vx = near(ctr, span);
                c[0] = vx; c[2] = vx;
                if (kind == 2) begin c[4] = vx; c[6] = vx; end
            end else if (kind == 3) begin
                c[6] = c[4]; c[0] = c[4] + coord_t'($urandom_range(0, 2)) - 1;
            end else if (kind == 4) begin
                // parallel: same direction vector
                c[6] = c[4] + (c[2] - c[0]); c[7] = c[5] + (c[3] - c[1]);
            end
            send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
        end
    endtask

    // sender pauses until all results are back
    task automatic drain();
        go_idle();
        while (expected_crossings.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_both_vertical();
        test_one_vertical();
        test_general();
        drain();
        test_random_pairs(375);
        drain();
        test_random_pairs(375);
        drain();
        repeat (LATENCY + 10) @(posedge aclk);
        $display("sent %0d pairs, checked %0d results, %0d hits", sent_count,
                 result_count, hit_count);
        $display("cases: general %0d, one vertical %0d, both vertical %0d",
                 case_count[segint_pkg::SEG_GENERAL], case_count[segint_pkg::SEG_ONE_VERT],
                 case_count[segint_pkg::SEG_BOTH_VERT]);
        if (mismatch_count == 0 && expected_crossings.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
